[sv/ktms_pkg.sv]
// ktms_pkg: shared types, codes and sizes for the key table membership search core
// no dependencies; imported by every module of the block
package ktms_pkg;

  localparam int MAX_KEYS = 1024;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int CNT_W    = KEY_AW + 1;
  localparam int IDX_W    = CNT_W + 1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_BINARY = 1'b1;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] query_value;
    logic               found;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic load;
    logic rd;
    logic step;
    logic emit;
    logic emit_found;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic hit;
  } status_t;

endpackage

[sv/ktms_datapath.sv]
// ktms_datapath: key memory, key count, mode register, search indices and result register
// depends on ktms_pkg; driven by ktms_ctrl through cmd_t, reports through status_t
module ktms_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic signed [31:0] value,
  input  logic              mode_we,
  input  logic              mode_data,
  input  ktms_pkg::cmd_t    cmd,
  output ktms_pkg::status_t status,
  output logic              done,
  output ktms_pkg::result_t result
);
  import ktms_pkg::*;

  logic signed [31:0] mem [MAX_KEYS];
  logic signed [31:0] rdata;
  logic signed [31:0] probe;
  logic [CNT_W-1:0]   key_count;
  logic               mode;
  logic signed [IDX_W-1:0] lo;
  logic signed [IDX_W-1:0] hi;
  logic signed [IDX_W-1:0] mid;
  logic signed [IDX_W-1:0] mid_next;
  logic [CNT_W-1:0]   k;
  logic [KEY_AW-1:0]  raddr;
  logic               full;

  assign full     = (key_count == CNT_W'(MAX_KEYS));
  assign mid_next = (lo + hi) >>> 1;
  assign raddr    = (mode == MODE_BINARY) ? mid_next[KEY_AW-1:0] : k[KEY_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem[key_count[KEY_AW-1:0]] <= value;
    end
    if (cmd.rd) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      mode      <= MODE_BINARY;
      done      <= 1'b0;
    end else begin
      if (mode_we) begin
        mode <= mode_data;
      end
      if (cmd.clear) begin
        key_count <= '0;
      end else if (cmd.append && !full) begin
        key_count <= key_count + CNT_W'(1);
      end
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      probe <= value;
      lo    <= '0;
      hi    <= $signed({1'b0, key_count}) - IDX_W'(1);
      k     <= '0;
    end else begin
      if (cmd.rd) begin
        mid <= mid_next;
      end
      if (cmd.step) begin
        k <= k + CNT_W'(1);
        if (rdata < probe) begin
          lo <= mid + IDX_W'(1);
        end else begin
          hi <= mid - IDX_W'(1);
        end
      end
    end
    if (cmd.emit) begin
      result.query_value <= probe;
      result.found       <= cmd.emit_found;
    end
  end

  assign status.more = (mode == MODE_BINARY) ? (lo <= hi) : (k < key_count);
  assign status.hit  = (rdata == probe);

endmodule

[sv/ktms_ctrl.sv]
// ktms_ctrl: state machine that sequences clears, appends and query probes
// depends on ktms_pkg; commands ktms_datapath through cmd_t
module ktms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        op,
  input  ktms_pkg::status_t status,
  output ktms_pkg::cmd_t    cmd,
  output logic              busy
);
  import ktms_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && op == OP_QUERY) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        state_next = status.more ? ST_CMP : ST_IDLE;
      end
      ST_CMP: begin
        state_next = status.hit ? ST_IDLE : ST_ISSUE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.clear  = accept && (op == OP_CLEAR);
        cmd.append = accept && (op == OP_APPEND);
        cmd.load   = accept && (op == OP_QUERY);
      end
      ST_ISSUE: begin
        cmd.rd   = status.more;
        cmd.emit = !status.more;
      end
      ST_CMP: begin
        cmd.step       = !status.hit;
        cmd.emit       = status.hit;
        cmd.emit_found = status.hit;
      end
      default: cmd = '0;
    endcase
  end

  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> state == ST_IDLE)
    else $error("emit did not return to idle");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_QUERY) |=> state == ST_ISSUE)
    else $error("query not started");

  a_cmp_after_issue: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> $past(cmd.rd))
    else $error("compare without read");

  a_found_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_found |-> (state == ST_CMP && status.hit))
    else $error("found outside a hit");

endmodule

[sv/key_table_membership_search_core.sv]
// key_table_membership_search_core: top level of the key table membership search
// depends on ktms_pkg, ktms_ctrl and ktms_datapath
//
// usage: an item (op, value) is taken when start is high and busy is low.
//   op clear empties the table, op append adds value at the end (ignored when
//   the table holds MAX_KEYS keys), op query looks value up; op 3 is dropped.
//   clear and append give no result.
// a query gives one result beat: done is high for exactly one cycle with
//   result.query_value and result.found; the receiver cannot stall it.
// the mode register (mode_we, mode_data) picks linear scan (0) or binary
//   search (1, keys appended in ascending order); write it only while idle.
// timing: every probe uses the single memory read port in two steps (read, then
//   compare). binary search makes up to floor(log2 n)+1 probes, linear scan up
//   to n probes. done rises in the same cycle that busy drops.
// reset: synchronous, active high; empties the table, selects binary mode,
//   needs no clearing pass since entries past the key count are never read.
module key_table_membership_search_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ktms_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output ktms_pkg::result_t result,
  input  logic              mode_we,
  input  logic              mode_data
);
  import ktms_pkg::*;

  cmd_t    cmd;
  status_t status;

  ktms_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (item.op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ktms_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (item.value),
    .mode_we   (mode_we),
    .mode_data (mode_data),
    .cmd       (cmd),
    .status    (status),
    .done      (done),
    .result    (result)
  );

endmodule

[tb/ktms_checker.sv]
// ktms_checker: watches the command and result ports of the key table search core,
// predicts each lookup from its own copy of the table and mode, and counts mismatches
// depends on ktms_pkg
`timescale 1ns / 1ps

module ktms_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  ktms_pkg::item_t   item,
  input  logic              done,
  input  ktms_pkg::result_t result,
  input  logic              mode_we,
  input  logic              mode_data,
  output int                fail_count,
  output int                pending,
  output int                checked
);
  import ktms_pkg::*;

  logic signed [31:0] key_table [MAX_KEYS];
  int                 key_count;
  logic               mode_reg;
  result_t            lookup_expect_q [$];

  function automatic logic predict_lookup(logic signed [31:0] probe);
    int   lo;
    int   hi;
    int   mid;
    logic hit;
    hit = 1'b0;
    if (mode_reg == MODE_LINEAR) begin
      for (int k = 0; k < key_count; k++) begin
        if (key_table[k] == probe) hit = 1'b1;
      end
    end else begin
      lo = 0;
      hi = key_count - 1;
      while (lo <= hi && !hit) begin
        mid = (lo + hi) / 2;
        if (key_table[mid] == probe) hit = 1'b1;
        else if (key_table[mid] < probe) lo = mid + 1;
        else hi = mid - 1;
      end
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      key_count = 0;
      mode_reg = MODE_BINARY;
      lookup_expect_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (done) begin
        if (lookup_expect_q.size() == 0) begin
          $display("%0t: result with none expected: value %0d found %0b", $time,
                   result.query_value, result.found);
          fail_count++;
        end else begin
          want = lookup_expect_q.pop_front();
          checked++;
          if (result.query_value !== want.query_value) begin
            $display("%0t: query_value expected %0d actual %0d", $time,
                     want.query_value, result.query_value);
            fail_count++;
          end
          if (result.found !== want.found) begin
            $display("%0t: found for %0d expected %0b actual %0b", $time,
                     want.query_value, want.found, result.found);
            fail_count++;
          end
        end
      end
      if (mode_we) mode_reg = mode_data;
      if (start && !busy) begin
        case (item.op)
          OP_CLEAR: key_count = 0;
          OP_APPEND: begin
            if (key_count < MAX_KEYS) begin
              key_table[key_count] = item.value;
              key_count++;
            end
          end
          OP_QUERY: begin
            want.query_value = item.value;
            want.found = predict_lookup(item.value);
            lookup_expect_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
    pending = lookup_expect_q.size();
  end

endmodule

[tb/key_table_membership_search_core_tb.sv]
// key_table_membership_search_core_tb: stimulus and verdict for the key table search core
// directed beats, a full-table pass and random table/lookup phases in both modes
// depends on ktms_pkg, key_table_membership_search_core and ktms_checker
`timescale 1ns / 1ps

module key_table_membership_search_core_tb;
  import ktms_pkg::*;

  localparam int ITEM_TARGET = 1100;
  localparam logic [1:0] OP_NOP = 2'd3;

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    done;
  result_t result;
  logic    mode_we;
  logic    mode_data;
  int      fail_count;
  int      pending;
  int      checked;

  logic signed [31:0] stored [$];
  logic               burst;
  int                 n_items;
  int                 n_lookups;
  int                 n_mode_writes;

  key_table_membership_search_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .mode_we   (mode_we),
    .mode_data (mode_data)
  );

  ktms_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .done       (done),
    .result     (result),
    .mode_we    (mode_we),
    .mode_data  (mode_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic send(input logic [1:0] op, input logic signed [31:0] value);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    repeat (gap) @(negedge clk) start <= 1'b0;
    @(negedge clk);
    start <= 1'b1;
    item.op <= op;
    item.value <= value;
    do @(posedge clk); while (busy);
    n_items++;
    if (op == OP_QUERY) n_lookups++;
    if (op == OP_CLEAR) stored.delete();
    if (op == OP_APPEND && stored.size() < MAX_KEYS) stored.push_back(value);
  endtask

  task automatic go_idle();
    @(negedge clk) start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    go_idle();
    @(negedge clk);
    mode_we <= 1'b1;
    mode_data <= m;
    @(negedge clk) mode_we <= 1'b0;
    n_mode_writes++;
  endtask

  task automatic lookup_mix(input int count);
    logic signed [31:0] v;
    int                 r;
    for (int q = 0; q < count; q++) begin
      r = $urandom_range(0, 9);
      if (r < 4 && stored.size() > 0) begin
        v = stored[$urandom_range(0, stored.size() - 1)];
      end else if (r < 6 && stored.size() > 0) begin
        v = stored[$urandom_range(0, stored.size() - 1)];
        v = $urandom_range(0, 1) ? v + 1 : v - 1;
      end else if (r == 6) begin
        v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      end else begin
        v = $urandom;
      end
      if ($urandom_range(0, 15) == 0) send(OP_NOP, $urandom);
      send(OP_QUERY, v);
    end
  endtask

  task automatic table_phase();
    logic signed [31:0] keys [64];
    logic signed [31:0] t;
    logic               m;
    logic               narrow;
    int                 n;
    int                 j;
    m = $urandom_range(0, 1);
    set_mode(m);
    burst = ($urandom_range(0, 3) == 0);
    send(OP_CLEAR, $urandom);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
    narrow = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < n; i++) keys[i] = narrow ? $urandom_range(0, 40) - 20 : $urandom;
    // binary mode needs ascending keys to go deep; leave some unsorted
    if ((m == MODE_BINARY && $urandom_range(0, 7) != 0) || $urandom_range(0, 1) == 0) begin
      for (int i = 1; i < n; i++) begin
        t = keys[i];
        j = i - 1;
        while (j >= 0 && keys[j] > t) begin
          keys[j + 1] = keys[j];
          j--;
        end
        keys[j + 1] = t;
      end
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send(OP_NOP, $urandom);
      send(OP_APPEND, keys[i]);
    end
    lookup_mix($urandom_range(5, 20));
    if ($urandom_range(0, 5) == 0) begin
      send(OP_CLEAR, $urandom);
      lookup_mix($urandom_range(1, 4));
    end
  endtask

  task automatic full_table_pass();
    longint v;
    set_mode(MODE_BINARY);
    send(OP_CLEAR, 0);
    burst = 1'b1;
    for (int i = 0; i < MAX_KEYS; i++) begin
      v = -64'sd2147483648 + longint'(i) * 4194304 + $urandom_range(0, 4194303);
      if (i == 0) v = -64'sd2147483648;
      if (i == MAX_KEYS - 1) v = 64'sd2147483647;
      send(OP_APPEND, v[31:0]);
    end
    burst = 1'b0;
    // table full: these are dropped
    send(OP_APPEND, 5);
    send(OP_APPEND, 32'sh7fffffff);
    send(OP_QUERY, 5);
    lookup_mix(30);
    set_mode(MODE_LINEAR);
    send(OP_QUERY, 32'sh7fffffff);
    send(OP_QUERY, 5);
    lookup_mix(6);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    mode_we = 1'b0;
    mode_data = 1'b0;
    burst = 1'b0;
    n_items = 0;
    n_lookups = 0;
    n_mode_writes = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // binary mode out of reset
    send(OP_QUERY, 0);
    send(OP_APPEND, 32'sh80000000);
    send(OP_APPEND, -5);
    send(OP_APPEND, 0);
    send(OP_APPEND, 7);
    send(OP_APPEND, 32'sh7fffffff);
    send(OP_QUERY, 32'sh80000000);
    send(OP_QUERY, 32'sh7fffffff);
    send(OP_QUERY, 0);
    send(OP_QUERY, 3);
    send(OP_QUERY, 8);
    send(OP_NOP, 32'sh7fffffff);
    send(OP_NOP, 32'sh80000000);
    send(OP_QUERY, 7);
    set_mode(MODE_LINEAR);
    send(OP_QUERY, 7);
    send(OP_QUERY, -5);
    send(OP_QUERY, -6);
    send(OP_APPEND, -100);
    send(OP_QUERY, -100);
    send(OP_CLEAR, 32'sh7fffffff);
    send(OP_QUERY, 7);
    send(OP_APPEND, 1);
    send(OP_QUERY, 1);

    full_table_pass();
    do table_phase(); while (n_items < ITEM_TARGET);
    set_mode(MODE_BINARY);

    go_idle();
    repeat (30) @(posedge clk);
    $display("%0d beats sent, %0d lookups, %0d mode writes, %0d results checked",
             n_items, n_lookups, n_mode_writes, checked);
    $display("covered a full table with dropped appends, empty tables, unsorted binary search");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
